FILE: hdl/assert_macros.svh
// assertion macros shared by the deque rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define DQ_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// trigger at one edge implies condition at the next edge
`define DQ_ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

// trigger implies condition at the same edge
`define DQ_ASSERT_IMPLY(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) else $error(msg);

`endif

FILE: hdl/dq_pkg.sv
// types and constants for the double-ended queue
`timescale 1ns / 1ps

package dq_pkg;

   localparam int DEPTH_DEF     = 16;
   localparam int WORD_BITS_DEF = 32;

   localparam int KIND_W   = 2;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 5;

   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH_FRONT = 2'd0,
      KIND_PUSH_REAR  = 2'd1,
      KIND_POP_FRONT  = 2'd2,
      KIND_POP_REAR   = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // operation broadcast to every cell, already gated by full and empty
   typedef struct packed {
      logic push_front;
      logic push_rear;
      logic pop_front;
      logic pop_rear;
   } dq_ctrl_type;

endpackage

FILE: hdl/dq_if.sv
// request and response channel interfaces for the double-ended queue
`timescale 1ns / 1ps

interface dq_req_if;
   import dq_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [KIND_W-1:0]          kind;
   logic signed [VALUE_W-1:0]  push_value;

   modport source (output valid, output kind, output push_value, input ready);
   modport sink (input valid, input kind, input push_value, output ready);
endinterface

interface dq_rsp_if;
   import dq_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [VALUE_W-1:0]  pop_value;
   logic [STATUS_W-1:0]        status;
   logic [OCC_W-1:0]           occupancy;

   modport source (output valid, output pop_value, output status, output occupancy,
                   input ready);
   modport sink (input valid, input pop_value, input status, input occupancy,
                 output ready);
endinterface

FILE: hdl/dq_cell.sv
// one storage cell of the shifting deque chain
`timescale 1ns / 1ps

module dq_cell import dq_pkg::*; #(
   parameter int WORD_BITS = WORD_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dq_ctrl_type          ctrl,
   input  logic [WORD_BITS-1:0] new_word,
   input  logic [WORD_BITS-1:0] prev_word,
   input  logic                 prev_valid,
   input  logic [WORD_BITS-1:0] next_word,
   input  logic                 next_valid,
   output logic [WORD_BITS-1:0] word,
   output logic                 valid,
   output logic                 tail
);

   logic [WORD_BITS-1:0] word_ff, word_in;
   logic                 valid_ff, valid_in;

   always_comb begin
      word_in  = word_ff;
      valid_in = valid_ff;
      if (ctrl.push_front) begin
         word_in  = prev_word;
         valid_in = prev_valid;
      end else if (ctrl.push_rear) begin
         // first empty cell behind a filled one takes the word
         if (!valid_ff && prev_valid) begin
            word_in  = new_word;
            valid_in = 1'b1;
         end
      end else if (ctrl.pop_front) begin
         word_in  = next_word;
         valid_in = next_valid;
      end else if (ctrl.pop_rear) begin
         if (valid_ff && !next_valid) begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word  = word_ff;
   assign valid = valid_ff;
   assign tail  = valid_ff & ~next_valid;

endmodule

FILE: hdl/double_ended_queue_top.sv
// channel    dir  fields
// req        in   kind, push_value
// rsp        out  pop_value, status, occupancy
//
// one beat per cycle while rsp is ready or no response is held; the response is registered
// and appears the cycle after the request beat, so throughput is set by the single cell update of the chain
// reset clears the cell valid bits and the count together, no sweep
// req stalls only while a response sits in the output register and rsp is not ready
// cell 0 is the front; the rear word is picked by the tail cell's one-hot select
`timescale 1ns / 1ps
`include "assert_macros.svh"

module double_ended_queue_top import dq_pkg::*; #(
   parameter int DEPTH     = DEPTH_DEF,
   parameter int WORD_BITS = WORD_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   dq_req_if.sink     req,
   dq_rsp_if.source   rsp
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WORD_BITS-1:0] cell_word [DEPTH];
   logic [DEPTH-1:0]     cell_vld;
   logic [DEPTH-1:0]     cell_tail;

   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 rsp_vld_ff, rsp_vld_in;
   logic [WORD_BITS-1:0] rsp_word_ff, rsp_word_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]     rsp_count_ff;

   logic                 req_acc;
   logic                 full, empty;
   kind_type             kind;
   dq_ctrl_type          ctrl;
   logic [WORD_BITS-1:0] new_word;
   logic [WORD_BITS-1:0] rear_word;
   logic [WORD_BITS+VALUE_W-1:0] in_wide;
   logic [WORD_BITS+VALUE_W-1:0] out_wide;
   logic [CNT_W+OCC_W-1:0]       occ_wide;

   assign req.ready = !rsp_vld_ff || rsp.ready;
   assign req_acc   = req.valid && req.ready;
   assign kind      = kind_type'(req.kind);
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);

   // sign-extend the 32-bit word, then keep the stored width
   assign in_wide  = {{WORD_BITS{req.push_value[VALUE_W-1]}}, req.push_value};
   assign new_word = in_wide[WORD_BITS-1:0];

   always_comb begin
      ctrl          = '0;
      count_in      = count_ff;
      rsp_status_in = STATUS_DONE;
      rsp_word_in   = '0;
      if (req_acc) begin
         case (kind)
            KIND_PUSH_FRONT, KIND_PUSH_REAR: begin
               if (full) begin
                  rsp_status_in = STATUS_FULL;
               end else begin
                  ctrl.push_front = (kind == KIND_PUSH_FRONT);
                  ctrl.push_rear  = (kind == KIND_PUSH_REAR);
                  count_in        = count_ff + CNT_W'(1);
               end
            end
            KIND_POP_FRONT: begin
               if (empty) begin
                  rsp_status_in = STATUS_EMPTY;
               end else begin
                  ctrl.pop_front = 1'b1;
                  rsp_word_in    = cell_word[0];
                  count_in       = count_ff - CNT_W'(1);
               end
            end
            KIND_POP_REAR: begin
               if (empty) begin
                  rsp_status_in = STATUS_EMPTY;
               end else begin
                  ctrl.pop_rear = 1'b1;
                  rsp_word_in   = rear_word;
                  count_in      = count_ff - CNT_W'(1);
               end
            end
            default: begin
               rsp_status_in = STATUS_DONE;
            end
         endcase
      end
   end

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         logic [WORD_BITS-1:0] prev_word, next_word;
         logic                 prev_valid, next_valid;
         if (i == 0) begin : g_first
            assign prev_word  = new_word;
            assign prev_valid = 1'b1;
         end else begin : g_mid
            assign prev_word  = cell_word[i-1];
            assign prev_valid = cell_vld[i-1];
         end
         if (i == DEPTH - 1) begin : g_last
            assign next_word  = '0;
            assign next_valid = 1'b0;
         end else begin : g_inner
            assign next_word  = cell_word[i+1];
            assign next_valid = cell_vld[i+1];
         end
         dq_cell #(.WORD_BITS(WORD_BITS)) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .new_word   (new_word),
            .prev_word  (prev_word),
            .prev_valid (prev_valid),
            .next_word  (next_word),
            .next_valid (next_valid),
            .word       (cell_word[i]),
            .valid      (cell_vld[i]),
            .tail       (cell_tail[i])
         );
      end
   endgenerate

   // tail flags are one-hot, so an and-or picks the rear word
   always_comb begin
      rear_word = '0;
      for (int k = 0; k < DEPTH; k++) begin
         rear_word = rear_word | (cell_word[k] & {WORD_BITS{cell_tail[k]}});
      end
   end

   assign rsp_vld_in = req_acc ? 1'b1 : (rsp.ready ? 1'b0 : rsp_vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         rsp_word_ff   <= rsp_word_in;
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= count_in;
      end
   end

   assign out_wide      = {{VALUE_W{rsp_word_ff[WORD_BITS-1]}}, rsp_word_ff};
   assign occ_wide      = {{OCC_W{1'b0}}, rsp_count_ff};
   assign rsp.valid     = rsp_vld_ff;
   assign rsp.pop_value = out_wide[VALUE_W-1:0];
   assign rsp.status    = rsp_status_ff;
   assign rsp.occupancy = occ_wide[OCC_W-1:0];

   `DQ_ASSERT_ALWAYS(a_count_cells, clock, reset, $countones(cell_vld) == count_ff, "count differs from filled cells")
   `DQ_ASSERT_ALWAYS(a_packed_front, clock, reset, ((cell_vld >> 1) & ~cell_vld) == '0, "gap in filled cells")
   `DQ_ASSERT_NEXT(a_rsp_follows, clock, reset, req_acc, rsp_vld_ff, "no response after request beat")
   `DQ_ASSERT_IMPLY(a_full_refusal, clock, reset, rsp_vld_ff && rsp_status_ff == STATUS_FULL, rsp_count_ff == CNT_W'(DEPTH), "full refusal without full queue")

endmodule
